### rtl/ilwi_pkg.sv
// ----------------------------------------------------------------------------
// ilwi_pkg: shared types and constants for the indexed list unit
// Sizes, command and status codes, transfer payloads and the control word
// that the list broadcasts to every entry cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ilwi_pkg;

    // List geometry.
    localparam int DEPTH      = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Fixed widths of the transfer fields.
    localparam int CMD_W   = 3;
    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 11;

    // Width that holds both an index and a count for range checks.
    localparam int CMP_W = CNT_W + INDEX_W;

    // Read tree geometry: groups of cells merged in the first stage.
    localparam int GRP  = 32;
    localparam int NGRP = (DEPTH + GRP - 1) / GRP;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 3'd0,
        CMD_READ   = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_START  = 3'd3,
        CMD_NEXT   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_STALE = 2'd3
    } t_status;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] data;
        t_status            status;
        logic [COUNT_W-1:0] count;
        logic               has_next;
    } t_out_item;

    // Control word seen by every entry cell.
    typedef struct packed {
        logic                  append;
        logic                  remove;
        logic [IDX_W-1:0]      rd_idx;
        logic [IDX_W-1:0]      wr_idx;
        logic [IDX_W-1:0]      rm_idx;
        logic [CNT_W-1:0]      cnt;
        logic [DATA_WIDTH-1:0] value;
    } t_cell_ctl;

endpackage

`default_nettype wire

### rtl/ilwi_cell.sv
// ----------------------------------------------------------------------------
// ilwi_cell: one entry of the list
// Holds one element, loads it on append, takes its upper neighbor's element
// when a remove closes a gap below it, and offers it to the read tree when
// its position is selected.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ilwi_cell
    import ilwi_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic [IDX_W-1:0]      i_pos,
    input  wire t_cell_ctl             i_ctl,
    input  wire logic [DATA_WIDTH-1:0] i_next,
    output logic      [DATA_WIDTH-1:0] o_entry,
    output logic      [DATA_WIDTH-1:0] o_rd
);

    logic [DATA_WIDTH-1:0] r_entry;
    logic                  w_shift;

    // This cell moves down when it lies at or above the removed entry and
    // its upper neighbor is still inside the list.
    assign w_shift = i_ctl.remove && (i_pos >= i_ctl.rm_idx)
                  && ((CNT_W'(i_pos) + CNT_W'(1)) < i_ctl.cnt);

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_ctl.append && (i_pos == i_ctl.wr_idx)) begin
            r_entry <= i_ctl.value;
        end else if (w_shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

    // Selected cells drive their element, all others drive zero.
    assign o_rd = (i_pos == i_ctl.rd_idx) ? r_entry : '0;

endmodule

`default_nettype wire

### rtl/ilwi_read_tree.sv
// ----------------------------------------------------------------------------
// ilwi_read_tree: registered OR tree over the cell read lines
// Only the selected cell drives a nonzero word, so a two-stage OR merge
// through the group and word registers yields the selected element.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ilwi_read_tree
    import ilwi_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic [DATA_WIDTH-1:0] i_word [DEPTH],
    output logic      [DATA_WIDTH-1:0] o_word
);

    logic [DATA_WIDTH-1:0] r_grp [NGRP];
    logic [DATA_WIDTH-1:0] n_grp [NGRP];
    logic [DATA_WIDTH-1:0] r_word;
    logic [DATA_WIDTH-1:0] n_word;

    // First stage: merge each group of cells.
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < GRP; k++) begin
                if (g * GRP + k < DEPTH) begin
                    n_grp[g] = n_grp[g] | i_word[g * GRP + k];
                end
            end
        end
    end

    // Second stage: merge the group results.
    always_comb begin
        n_word = '0;
        for (int g = 0; g < NGRP; g++) begin
            n_word = n_word | r_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp  <= n_grp;
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

### rtl/indexed_list_with_iterator_unit.sv
// ----------------------------------------------------------------------------
// indexed_list_with_iterator_unit: fixed-capacity ordered list with iterator
// Top level: command sequencing, list and iterator state, result register.
// ----------------------------------------------------------------------------
// The list holds up to DEPTH elements in a row of entry cells. Each command
// passes through S_IDLE to be accepted, S_SEL and S_MRG for the registered
// read tree that brings the selected cell's element out, and S_DONE to commit.
// Its result is loaded into the output register at commit, and no new command
// is accepted before that commit, so commands never overlap. A remove shifts
// every later entry down by one place in the commit step, so remove costs
// no more than read. The next command is accepted in the cycle after commit,
// while the previous result may still wait in the output register; a result
// is loaded only once that register is free, so a stalled output stretches
// the commit step. Entries are not cleared by reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_with_iterator_unit
    import ilwi_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SEL  = 4'b0010,
        S_MRG  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    t_cmd               r_cmd;
    logic [INDEX_W-1:0] r_index;
    logic [VALUE_W-1:0] r_value;
    logic [IDX_W-1:0]   r_sel;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_pos, n_pos;
    logic [CNT_W-1:0]   r_end, n_end;
    logic               r_live, n_live;
    logic               r_ovalid;
    t_out_item          r_out, n_out;

    logic                  w_accept;
    logic                  w_commit;
    logic                  w_in_range;
    logic                  w_append;
    logic                  w_remove;
    t_cell_ctl             w_ctl;
    logic [DATA_WIDTH-1:0] w_entry [DEPTH];
    logic [DATA_WIDTH-1:0] w_rd    [DEPTH];
    logic [DATA_WIDTH-1:0] w_rdata;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_commit    = (r_state == S_DONE) && (!r_ovalid || i_out_ready);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_accept) n_state = S_SEL;
            S_SEL:  n_state = S_MRG;
            S_MRG:  n_state = S_DONE;
            S_DONE: if (w_commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Latch the command; the cell select is the index, or the iterator
    // position for a next command.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= t_cmd'(i_in_data.cmd);
            r_index <= i_in_data.index;
            r_value <= i_in_data.value;
            if (t_cmd'(i_in_data.cmd) == CMD_NEXT) begin
                r_sel <= IDX_W'(r_pos);
            end else begin
                r_sel <= IDX_W'(i_in_data.index);
            end
        end
    end

    assign w_in_range = CMP_W'(r_index) < CMP_W'(r_count);

    // Result and state update at commit.
    always_comb begin
        n_count  = r_count;
        n_pos    = r_pos;
        n_end    = r_end;
        n_live   = r_live;
        w_append = 1'b0;
        w_remove = 1'b0;
        n_out    = '0;
        n_out.status = ST_OK;
        case (r_cmd)
            CMD_APPEND: begin
                if (CMP_W'(r_count) >= CMP_W'(DEPTH)) begin
                    n_out.status = ST_FULL;
                end else begin
                    w_append = 1'b1;
                    n_count  = r_count + CNT_W'(1);
                    n_live   = 1'b0;
                end
            end
            CMD_READ: begin
                if (!w_in_range) begin
                    n_out.status = ST_RANGE;
                end else begin
                    n_out.data = VALUE_W'(w_rdata);
                end
            end
            CMD_REMOVE: begin
                if (!w_in_range) begin
                    n_out.status = ST_RANGE;
                end else begin
                    n_out.data = VALUE_W'(w_rdata);
                    w_remove   = 1'b1;
                    n_count    = r_count - CNT_W'(1);
                    n_live     = 1'b0;
                end
            end
            CMD_START: begin
                n_pos  = '0;
                n_end  = r_count;
                n_live = 1'b1;
            end
            CMD_NEXT: begin
                if (!r_live) begin
                    n_out.status = ST_STALE;
                end else if ((r_pos >= r_end) || (r_pos >= r_count)) begin
                    n_out.status = ST_RANGE;
                end else begin
                    n_out.data = VALUE_W'(w_rdata);
                    n_pos      = r_pos + CNT_W'(1);
                end
            end
            default: ;
        endcase
        n_out.count    = COUNT_W'(n_count);
        n_out.has_next = n_live && (n_pos < n_end);
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_pos    <= '0;
            r_end    <= '0;
            r_live   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_count  <= n_count;
                r_pos    <= n_pos;
                r_end    <= n_end;
                r_live   <= n_live;
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out <= n_out;
        end
    end

    // Control word broadcast to the cells.
    always_comb begin
        w_ctl.append = w_commit && w_append;
        w_ctl.remove = w_commit && w_remove;
        w_ctl.rd_idx = r_sel;
        w_ctl.wr_idx = IDX_W'(r_count);
        w_ctl.rm_idx = IDX_W'(r_index);
        w_ctl.cnt    = r_count;
        w_ctl.value  = DATA_WIDTH'(r_value);
    end

    // Row of entry cells, each fed by its upper neighbor.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_next;
        if (g + 1 < DEPTH) begin : g_mid
            assign w_next = w_entry[g + 1];
        end else begin : g_top
            assign w_next = '0;
        end
        ilwi_cell u_cell (
            .i_clk   (i_clk),
            .i_pos   (IDX_W'(g)),
            .i_ctl   (w_ctl),
            .i_next  (w_next),
            .o_entry (w_entry[g]),
            .o_rd    (w_rd[g])
        );
    end

    // Selected element, valid in the commit state.
    ilwi_read_tree u_read_tree (
        .i_clk  (i_clk),
        .i_word (w_rd),
        .o_word (w_rdata)
    );

endmodule

`default_nettype wire

### dv/indexed_list_with_iterator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_with_iterator_unit_tb: self-checking bench for the list unit
// Sends append, read, remove and iterator commands through the input
// handshake. A behavioral copy of the list predicts every result, and each
// output transfer is compared field by field. Both sides stall at random.
// ----------------------------------------------------------------------------
module indexed_list_with_iterator_unit_tb;
    import ilwi_pkg::*;

    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int LONG_HOLD_CYCLES = 150;
    localparam int SETTLE_CYCLES    = 20;
    localparam int RANDOM_ITEMS     = 120;
    localparam int CALM_TAIL        = 40;
    localparam int LIST_SOFT_CAP    = 48;
    localparam int MAX_PRINTED      = 100;
    localparam int SHRINK_REMOVES   = 16;

    // Command codes that the block has no operation for.
    localparam logic [CMD_W-1:0]   CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_W-1:0]   CMD_SPARE_LAST  = 3'd7;
    localparam logic [INDEX_W-1:0] INDEX_MAX       = '1;
    localparam logic [VALUE_W-1:0] VALUE_MAX       = '1;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      out_ready = 1'b0;
    t_in_item  in_data   = '0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_data;

    // Results predicted but not yet seen, oldest first.
    t_out_item expected_results[$];
    int        error_count     = 0;
    int        command_count   = 0;
    bit        tx_idle_on      = 1'b1;
    bit        rx_idle_on      = 1'b1;
    int        rx_hold_request = 0;

    // Behavioral copy of the list and its iterator.
    logic [DATA_WIDTH-1:0] list_mem [DEPTH];
    int                    list_len = 0;
    int                    it_pos   = 0;
    int                    it_end   = 0;
    bit                    it_live  = 1'b0;

    indexed_list_with_iterator_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial forever #1 clk = ~clk;

    // Apply one command to the list copy and return the result it yields.
    function automatic t_out_item model_command(t_in_item item);
        t_out_item res;
        int        idx;
        res = '0;
        idx = int'(item.index);
        case (item.cmd)
            CMD_APPEND: begin
                if (list_len >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    list_mem[list_len] = item.value[DATA_WIDTH-1:0];
                    list_len++;
                    it_live = 1'b0;
                end
            end
            CMD_READ: begin
                if (idx >= list_len) res.status = ST_RANGE;
                else res.data = list_mem[idx];
            end
            CMD_REMOVE: begin
                if (idx >= list_len) begin
                    res.status = ST_RANGE;
                end else begin
                    res.data = list_mem[idx];
                    for (int i = idx; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
                    list_len--;
                    it_live = 1'b0;
                end
            end
            CMD_START: begin
                it_pos  = 0;
                it_end  = list_len;
                it_live = 1'b1;
            end
            CMD_NEXT: begin
                if (!it_live) begin
                    res.status = ST_STALE;
                end else if (it_pos >= it_end || it_pos >= list_len) begin
                    res.status = ST_RANGE;
                end else begin
                    res.data = list_mem[it_pos];
                    it_pos++;
                end
            end
            default: ;
        endcase
        res.count    = COUNT_W'(list_len);
        res.has_next = it_live && (it_pos < it_end);
        return res;
    endfunction

    // Mostly an index inside the list, sometimes anywhere in the field.
    function automatic logic [INDEX_W-1:0] pick_index();
        if (list_len > 0 && $urandom_range(0, 99) < 85)
            return INDEX_W'($urandom_range(0, list_len - 1));
        return INDEX_W'($urandom_range(0, int'(INDEX_MAX)));
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (error_count < MAX_PRINTED)
            $display("%0t ns mismatch on %s: expected %0h, got %0h", $time, what, want, got);
        error_count++;
    endtask

    // Offer one command, optionally after a gap, and predict its result once
    // the transfer happens. Valid stays high for a following command.
    task automatic send_command(input logic [CMD_W-1:0] cmd,
                                input logic [INDEX_W-1:0] index,
                                input logic [VALUE_W-1:0] value);
        t_in_item item;
        item.cmd   = cmd;
        item.index = index;
        item.value = value;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_results.push_back(model_command(item));
        if (cmd <= CMD_NEXT) command_count++;
    endtask

    // Stop offering and wait until every predicted result has come out.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    // Range, stale and unused-code behavior on an empty list.
    task automatic test_empty_list();
        send_command(CMD_READ, '0, '0);
        send_command(CMD_REMOVE, '0, '0);
        send_command(CMD_READ, INDEX_MAX, '0);
        send_command(CMD_NEXT, '0, '0);
        send_command(CMD_START, '0, '0);
        send_command(CMD_NEXT, '0, '0);
        for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
            send_command(CMD_W'(c), INDEX_MAX, VALUE_MAX);
        drain_results();
    endtask

    // Every operation at least once, with extreme values and an iterator made stale.
    task automatic test_basic_ops();
        send_command(CMD_APPEND, '0, '0);
        send_command(CMD_APPEND, INDEX_MAX, VALUE_MAX);
        send_command(CMD_APPEND, '0, 32'h5A5A_C3C3);
        send_command(CMD_READ, 10'd1, '0);
        send_command(CMD_READ, 10'd3, '0);
        send_command(CMD_START, '0, '0);
        send_command(CMD_NEXT, '0, '0);
        send_command(CMD_NEXT, '0, '0);
        send_command(CMD_APPEND, '0, 32'h0000_0001);
        send_command(CMD_NEXT, '0, '0);
        send_command(CMD_REMOVE, 10'd1, '0);
        send_command(CMD_START, '0, '0);
        send_command(CMD_REMOVE, 10'd2, '0);
        send_command(CMD_NEXT, '0, '0);
        send_command(CMD_REMOVE, '0, '0);
        send_command(CMD_READ, 10'd1, '0);
        drain_results();
    endtask

    // The receiver holds off for a long stretch while commands keep coming.
    task automatic test_output_stall();
        tx_idle_on      = 1'b0;
        rx_idle_on      = 1'b0;
        rx_hold_request = LONG_HOLD_CYCLES;
        repeat (24) begin
            if ($urandom_range(0, 1) == 0) send_command(CMD_APPEND, pick_index(), $urandom());
            else send_command(CMD_READ, pick_index(), $urandom());
        end
        drain_results();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Fill to capacity, work at the top index, then shrink by SHRINK_REMOVES entries.
    task automatic test_full_list();
        send_command(CMD_START, '0, '0);
        while (list_len < DEPTH) send_command(CMD_APPEND, pick_index(), $urandom());
        send_command(CMD_APPEND, '0, VALUE_MAX);
        send_command(CMD_START, '0, '0);
        send_command(CMD_NEXT, '0, '0);
        // A refused append leaves the iterator live.
        send_command(CMD_APPEND, INDEX_MAX, '0);
        send_command(CMD_NEXT, '0, '0);
        send_command(CMD_READ, INDEX_MAX, '0);
        send_command(CMD_REMOVE, INDEX_MAX, '0);
        send_command(CMD_READ, INDEX_MAX, '0);
        send_command(CMD_REMOVE, '0, '0);
        while (list_len > DEPTH - SHRINK_REMOVES) begin
            if ($urandom_range(0, 9) == 0) send_command(CMD_READ, pick_index(), $urandom());
            else send_command(CMD_REMOVE, INDEX_W'($urandom_range(0, list_len - 1)),
                              $urandom());
        end
        drain_results();
    endtask

    // Random mix of short command sequences; idling stops near the end.
    task automatic test_random_mix();
        int base;
        int done;
        int kind;
        int steps;
        base = command_count;
        while (command_count - base < RANDOM_ITEMS) begin
            done       = command_count - base;
            tx_idle_on = (done < RANDOM_ITEMS - CALM_TAIL) && ((done % 200) < 150);
            rx_idle_on = tx_idle_on;
            kind       = $urandom_range(0, 99);
            if (kind < 30) begin
                // Iterator walk, at times running past the end, with a stray update now and then.
                send_command(CMD_START, pick_index(), $urandom());
                steps = list_len + $urandom_range(0, 2);
                repeat (steps) begin
                    kind = $urandom_range(0, 99);
                    if (kind < 5) send_command(CMD_APPEND, pick_index(), $urandom());
                    else if (kind < 8) send_command(CMD_REMOVE, pick_index(), $urandom());
                    else if (kind < 20) send_command(CMD_READ, pick_index(), $urandom());
                    send_command(CMD_NEXT, pick_index(), $urandom());
                end
            end else if (kind < 50 && list_len < LIST_SOFT_CAP) begin
                repeat ($urandom_range(1, 6)) send_command(CMD_APPEND, pick_index(), $urandom());
            end else if (kind < 70) begin
                repeat ($urandom_range(1, 3)) send_command(CMD_REMOVE, pick_index(), $urandom());
            end else if (kind < 90) begin
                repeat ($urandom_range(1, 4)) send_command(CMD_READ, pick_index(), $urandom());
            end else if (kind < 96) begin
                if ($urandom_range(0, 1) == 0) send_command(CMD_NEXT, pick_index(), $urandom());
                else send_command(CMD_START, pick_index(), $urandom());
            end else begin
                send_command(CMD_W'($urandom_range(int'(CMD_SPARE_FIRST), int'(CMD_SPARE_LAST))),
                             pick_index(), $urandom());
            end
        end
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
    endtask

    // Output side: random stall bursts, plus the long hold when requested.
    initial begin : result_sink
        int hold;
        @(posedge clk);
        forever begin
            if (rx_hold_request > 0) begin
                hold            = rx_hold_request;
                rx_hold_request = 0;
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compare each output transfer with the oldest prediction.
    always @(posedge clk) begin : result_check
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing pending", '0, 32'(out_data.data));
            end else begin
                want = expected_results.pop_front();
                if (out_data.data !== want.data)
                    report_mismatch("data", 32'(want.data), 32'(out_data.data));
                if (out_data.status !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(out_data.status));
                if (out_data.count !== want.count)
                    report_mismatch("count", 32'(want.count), 32'(out_data.count));
                if (out_data.has_next !== want.has_next)
                    report_mismatch("has_next", 32'(want.has_next), 32'(out_data.has_next));
            end
        end
    end

    // End the run when no transfer happens for too long.
    initial begin : watchdog
        int quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
            else quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : main_sequence
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_basic_ops();
        test_output_stall();
        test_random_mix();
        test_full_list();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
